[sv/biec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biec_pkg: shared types and constants of the equal-interval cutter
// Payload structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package biec_pkg;

    localparam int COORD_W   = 32;
    localparam int DIM_W     = 3;
    localparam int CUT_W     = 6;
    localparam int MAX_CUTS  = 63;
    localparam int DIM_COUNT = 8;
    localparam int DIV_W     = CUT_W + 1;
    localparam int STEP_W    = $clog2(COORD_W);

    typedef struct packed {
        logic [DIM_W-1:0]   dim_index;
        logic [COORD_W-1:0] box_start;
        logic [COORD_W-1:0] box_end;
        logic [CUT_W-1:0]   cut_count;
    } t_in_item;

    typedef struct packed {
        logic [DIM_W-1:0]   cut_dim;
        logic [CUT_W-1:0]   piece_index;
        logic [COORD_W-1:0] piece_start;
        logic [COORD_W-1:0] piece_end;
        logic               last_piece;
        logic               overrun;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic req_ok;
        logic div_last;
        logic slot_free;
        logic last;
    } t_status;

endpackage

[sv/biec_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biec_ctrl: sequencing controller
// Takes a request, runs the serial divide, then issues one piece per free slot.
// ----------------------------------------------------------------------------
module biec_ctrl
    import biec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // drop requests for a dimension the box does not have
                if (i_in_valid && i_status.req_ok) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.emit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && i_status.req_ok;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.slot_free)
        else $error("piece issued into an occupied output slot");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_status.slot_free && i_status.last)
        |=> r_state == ST_IDLE)
        else $error("run did not end after its last piece");

    a_divide_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && !i_status.div_last) |=> r_state == ST_DIVIDE)
        else $error("divide left before its last step");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_cmd.emit && !o_cmd.div_step))
        else $error("datapath commanded while waiting for a request");

endmodule

[sv/biec_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biec_dpath: divider and piece generator
// Restoring divide one quotient bit per cycle, then one piece per emit.
// ----------------------------------------------------------------------------
module biec_dpath
    import biec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    input  logic      i_out_ready,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [COORD_W-1:0] r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [STEP_W-1:0]  r_step;
    logic [COORD_W-1:0] r_cur;
    logic [COORD_W-1:0] r_end;
    logic [DIM_W-1:0]   r_dim;
    logic [CUT_W-1:0]   r_n;
    logic [CUT_W-1:0]   r_idx;
    logic               r_wrapped;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CUT_W-1:0]   sat_n;
    logic [COORD_W-1:0] span;
    logic [DIV_W:0]     rem_sh;
    logic               rem_ge;
    logic [DIV_W:0]     rem_sub;
    logic [COORD_W:0]   sum_t;
    logic [COORD_W-1:0] t_end;
    logic               is_last;
    t_out_item          piece;

    always_comb begin
        sat_n = (i_in_item.cut_count > CUT_W'(MAX_CUTS)) ? CUT_W'(MAX_CUTS)
                                                          : i_in_item.cut_count;
        span  = i_in_item.box_end - i_in_item.box_start;
    end

    always_comb begin
        rem_sh  = {r_rem, r_quo[COORD_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // r_quo holds the piece length once the divide is done
    always_comb begin
        sum_t   = {1'b0, r_cur} + {1'b0, r_quo};
        t_end   = sum_t[COORD_W-1:0];
        is_last = (r_idx == r_n);

        piece.cut_dim     = r_dim;
        piece.piece_index = r_idx;
        piece.piece_start = r_cur;
        piece.piece_end   = is_last ? r_end : t_end;
        piece.last_piece  = is_last;
        piece.overrun     = r_wrapped || (r_cur > r_end);
    end

    always_comb begin
        o_status.req_ok    = int'(i_in_item.dim_index) < DIM_COUNT;
        o_status.div_last  = (r_step == STEP_W'(COORD_W - 1));
        o_status.slot_free = !r_out_valid || i_out_ready;
        o_status.last      = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo     <= span;
            r_rem     <= '0;
            r_div     <= {1'b0, sat_n} + DIV_W'(1);
            r_step    <= '0;
            r_cur     <= i_in_item.box_start;
            r_end     <= i_in_item.box_end;
            r_dim     <= i_in_item.dim_index;
            r_n       <= sat_n;
            r_idx     <= '0;
            r_wrapped <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[COORD_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end else if (i_cmd.emit) begin
            // advance to one past this piece's end; latch any coordinate wrap
            r_cur     <= t_end + COORD_W'(1);
            r_idx     <= r_idx + CUT_W'(1);
            r_wrapped <= r_wrapped || sum_t[COORD_W] || (&t_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= piece;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !i_cmd.emit) |=> r_out_valid)
        else $error("pending piece lost without a transfer");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_idx <= r_n)
        else $error("piece index ran past the cut count");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_div != '0)
        else $error("divide started with a zero divisor");

endmodule

[sv/box_interval_equal_cutter.sv]
`timescale 1ns / 1ps
// Sequence: the request transfer is followed by 32 divide steps, then the single
//   output register; further pieces follow one per cycle while the output accepts them.
// Requests: no new request is taken until the last piece of a run is issued,
//   a pace set by the serial one-bit-per-cycle divider and the single output register.
// Reset: synchronous, active low; clears the controller and the output valid.
// ----------------------------------------------------------------------------
// box_interval_equal_cutter: equal-interval partition of one box dimension
// Splits [start,end] into n+1 pieces of length (end-start)/(n+1); the last ends at end.
// ----------------------------------------------------------------------------
module box_interval_equal_cutter
    import biec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd    cmd;
    t_status status;

    biec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    biec_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[tb/tb_box_interval_equal_cutter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_interval_equal_cutter: self-checking bench for the equal-interval cutter
// Sends cut requests over valid/ready and predicts every piece of each run.
// The output stream is checked in order, field by field, under three mixes of
// input and output idling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_box_interval_equal_cutter;
    import biec_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int PHASE_ITEMS     = 34;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;

    // Expected pieces of every accepted request, oldest first
    class cut_scoreboard;
        t_out_item          pieces_due[$];
        logic [COORD_W-1:0] seg_length;
        logic [COORD_W-1:0] next_start;
        logic [COORD_W-1:0] saved_end;
        logic [DIM_W-1:0]   held_dim;
        int unsigned        errors;
        int unsigned        requests;
        int unsigned        pieces_checked;

        function new();
            seg_length     = '0;
            next_start     = '0;
            saved_end      = '0;
            held_dim       = '0;
            errors         = 0;
            requests       = 0;
            pieces_checked = 0;
        endfunction

        // the cut count never exceeds MAX_CUTS and dim_index never reaches
        // DIM_COUNT at these widths, so every request yields count + 1 pieces.
        function void note_request(t_in_item req);
            logic [COORD_W-1:0] cur;
            logic [COORD_W-1:0] t;
            logic [COORD_W-1:0] u;
            logic [DIV_W-1:0]   pieces;
            logic               wrapped;
            t_out_item          piece;
            pieces     = DIV_W'(req.cut_count) + 1'b1;
            seg_length = (req.box_end - req.box_start) / COORD_W'(pieces);
            saved_end  = req.box_end;
            held_dim   = req.dim_index;
            cur        = req.box_start;
            wrapped    = 1'b0;
            for (int i = 0; i <= int'(req.cut_count); i++) begin
                t                 = cur + seg_length;
                piece.cut_dim     = req.dim_index;
                piece.piece_index = CUT_W'(i);
                piece.piece_start = cur;
                piece.last_piece  = (i == int'(req.cut_count));
                piece.piece_end   = piece.last_piece ? req.box_end : t;
                piece.overrun     = wrapped || (cur > req.box_end);
                pieces_due        = {pieces_due, piece};
                // once a start wraps, every later piece stays flagged
                u = t + 1'b1;
                if (t < cur || u < t) wrapped = 1'b1;
                cur = u;
            end
            next_start = cur;
            requests++;
        endfunction

        function void check_field(string field, logic [COORD_W-1:0] want,
                                  logic [COORD_W-1:0] seen);
            if (seen !== want) begin
                errors++;
                $error("%s mismatch: expected %0h, got %0h", field, want, seen);
            end
        endfunction

        function void check_piece(t_out_item got);
            t_out_item want;
            if (pieces_due.size() == 0) begin
                errors++;
                $error("piece with nothing outstanding: start %0h end %0h",
                       got.piece_start, got.piece_end);
                return;
            end
            want = pieces_due.pop_front();
            pieces_checked++;
            check_field("cut_dim", COORD_W'(want.cut_dim), COORD_W'(got.cut_dim));
            check_field("piece_index", COORD_W'(want.piece_index),
                        COORD_W'(got.piece_index));
            check_field("piece_start", want.piece_start, got.piece_start);
            check_field("piece_end", want.piece_end, got.piece_end);
            check_field("last_piece", COORD_W'(want.last_piece),
                        COORD_W'(got.last_piece));
            check_field("overrun", COORD_W'(want.overrun), COORD_W'(got.overrun));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    cut_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    logic          hold_request;
    int            quiet_cycles;

    box_interval_equal_cutter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_in_item make_request(int unsigned dim,
                                              logic [COORD_W-1:0] lo_bound,
                                              logic [COORD_W-1:0] hi_bound,
                                              int unsigned cuts);
        t_in_item req;
        req.dim_index = DIM_W'(dim);
        req.box_start = lo_bound;
        req.box_end   = hi_bound;
        req.cut_count = CUT_W'(cuts);
        return req;
    endfunction

    // Mostly ordered intervals with short runs; some tight spans, some near
    // the top of the coordinate range, some with start above end.
    function automatic t_in_item random_request();
        t_in_item           req;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        int unsigned        pick;
        req.dim_index = DIM_W'($urandom_range(DIM_COUNT - 1));
        pick = $urandom_range(99);
        if (pick < 70)
            req.cut_count = CUT_W'($urandom_range(7));
        else if (pick < 90)
            req.cut_count = CUT_W'($urandom_range(24, 8));
        else
            req.cut_count = CUT_W'($urandom_range(MAX_CUTS, 25));
        a    = $urandom;
        b    = $urandom;
        pick = $urandom_range(99);
        if (pick < 55) begin
            req.box_start = (a < b) ? a : b;
            req.box_end   = (a < b) ? b : a;
        end else if (pick < 70) begin
            req.box_start = a;
            req.box_end   = a + COORD_W'($urandom_range(int'(req.cut_count)));
        end else if (pick < 85) begin
            req.box_start = 32'hFFFF_FFFF - COORD_W'($urandom_range(4095));
            req.box_end   = 32'hFFFF_FFFF - COORD_W'($urandom_range(7));
        end else begin
            req.box_start = (a < b) ? b : a;
            req.box_end   = (a < b) ? a : b;
        end
        return req;
    endfunction

    task automatic send_item(t_in_item req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    task automatic run_directed();
        send_item(make_request(0, 32'h0, 32'h0, 0));
        send_item(make_request(7, 32'h0, 32'hFFFF_FFFF, 0));
        send_item(make_request(1, 32'h0, 32'hFFFF_FFFF, MAX_CUTS));
        send_item(make_request(2, 32'h0, 32'd99, 9));
        send_item(make_request(6, 32'h0, 32'd127, MAX_CUTS));
        // more cuts than span: zero length, starts run past the end
        send_item(make_request(3, 32'd10, 32'd12, 5));
        send_item(make_request(4, 32'd1000, 32'd1000, MAX_CUTS));
        send_item(make_request(5, 32'h0, 32'd63, MAX_CUTS));
        // coordinate wrap at the top of the range
        send_item(make_request(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        send_item(make_request(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3));
        send_item(make_request(3, 32'hFFFF_FF00, 32'hFFFF_FFFF, MAX_CUTS));
        // start above end: the span wraps; the last two are ordered spans
        send_item(make_request(0, 32'd100, 32'd50, 2));
        send_item(make_request(1, 32'hFFFF_FFFE, 32'h0, 1));
        send_item(make_request(2, 32'h8000_0000, 32'h7FFF_FFFF, MAX_CUTS));
        send_item(make_request(4, 32'h1234_5678, 32'h9ABC_DEF0, 1));
        send_item(make_request(7, 32'h5555_5555, 32'hAAAA_AAAA, 42));
    endtask

    // Output side: random stalls, plus one long hold-off on request
    initial begin : output_side
        int hold_left;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_piece(o_out_item);
        end
    end

    // End the run if no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d pieces outstanding",
                     quiet_cycles, sb.pieces_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_ready   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 30;
        run_directed();

        send_idle_pct = 17;
        recv_idle_pct = 78;
        repeat (PHASE_ITEMS) send_item(random_request());

        send_idle_pct = 78;
        recv_idle_pct = 17;
        repeat (PHASE_ITEMS) send_item(random_request());

        // no idling; the output holds off first so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (PHASE_ITEMS) send_item(random_request());

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pieces_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d cut requests and %0d pieces: edge intervals, wraps,",
                 sb.requests, sb.pieces_checked);
        $display("over-count runs, three idle mixes and a %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (sb.errors == 0 && sb.pieces_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[box_interval_equal_cutter.f]
sv/biec_pkg.sv
sv/biec_ctrl.sv
sv/biec_dpath.sv
sv/box_interval_equal_cutter.sv
tb/tb_box_interval_equal_cutter.sv
